>>> hdl/sgwu_pkg.sv
// ----------------------------------------------------------------------------
// sgwu_pkg: shared types, constants and exp helpers
// Register indexes, field widths, pipeline tags and the 2^-y table.
// ----------------------------------------------------------------------------
package sgwu_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int TIME_W     = 32;
  localparam int MU_W       = 24;
  localparam int PRM_W      = 16;
  localparam int IDX_W      = 16;
  localparam int WGT_W      = 16;

  // Window divider: quotient bits (one per stage) and remainder width.
  localparam int QW    = 25;
  localparam int REM_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MU_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA_P = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_P = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MU_D    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA_D = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_D  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd7;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [17:0] TWO_Q16   = 18'd131072;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] idx;
    logic [WGT_W-1:0] w;
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic        far;
    logic [33:0] p;
  } div_side_t;

  // 2^(-j/16) in Q.16.
  function automatic logic [16:0] pow2_neg(input logic [4:0] j);
    logic [16:0] v;
    case (j)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

  // First half of exp(-x): scale a saturated Q.16 argument by log2(e).
  function automatic logic [23:0] exp_scale(input logic [22:0] x);
    logic [39:0] prod;
    prod = {17'b0, x} * {23'b0, LOG2E_Q16};
    return prod[39:16];
  endfunction

  // Second half of exp(-x): table, linear interpolation and integer shift.
  function automatic logic [16:0] exp_pow2(input logic [23:0] y);
    logic [16:0] lo;
    logic [16:0] hi;
    logic [11:0] diff;
    logic [23:0] corr;
    logic [16:0] v;
    lo   = pow2_neg({1'b0, y[15:12]});
    hi   = pow2_neg({1'b0, y[15:12]} + 5'd1);
    diff = 12'(lo - hi);
    corr = {12'b0, diff} * {12'b0, y[11:0]};
    v    = lo - {5'b0, corr[23:12]};
    if (|y[23:21]) begin
      return 17'd0;
    end
    return v >> y[20:16];
  endfunction

endpackage

>>> hdl/sgwu_if.sv
// ----------------------------------------------------------------------------
// sgwu_if: stream interfaces of the weight update block
// Request channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface sgwu_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] synapse_index;
  logic [15:0] weight;
  logic [15:0] cooperativity;
  logic [31:0] pre_spike_time;
  logic [31:0] post_spike_time;

  modport source (output valid, operation, synapse_index, weight, cooperativity,
                  pre_spike_time, post_spike_time, input ready);
  modport sink   (input valid, operation, synapse_index, weight, cooperativity,
                  pre_spike_time, post_spike_time, output ready);
endinterface

interface sgwu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] synapse_index_out;
  logic [15:0] new_weight;
  logic        clipped;

  modport source (output valid, synapse_index_out, new_weight, clipped, input ready);
  modport sink   (input valid, synapse_index_out, new_weight, clipped, output ready);
endinterface

>>> hdl/stdp_gaussian_weight_update.sv
// ----------------------------------------------------------------------------
// stdp_gaussian_weight_update: Gaussian-window STDP weight update
// Fully pipelined, one synapse update per cycle unless stalled, saturating Q2.14 result.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_i (operation, synapse index, weight, cooperativity
//   and the two spike times) and each one gives exactly one result on out_o
//   (synapse index, saturated new weight, clipped flag). A transfer takes
//   place on a rising edge with valid and ready both high.
//   The user writes the window parameters, decay rates and gains through the
//   plain port cfg_we_i / cfg_idx_i / cfg_data_i only while no request is in
//   flight, not enforced by the block; each write acts on the following edge.
//   There are 34 register stages: five front stages, 25 stages of the
//   one-bit-a-cycle window divider, three exp and product stages and the
//   output register. Throughput is one request per cycle, set by that
//   pipeline, as long as the receiver does not stall the output.
//   Each stage loads whenever it is empty or the stage after it moves on, so
//   a stalled receiver holds the output register while empty stages behind
//   it keep filling; nothing is lost or repeated.
//   Reset clears every valid bit and returns the configuration registers
//   to their default values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module stdp_gaussian_weight_update import sgwu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  sgwu_in_if.sink               in_i,
  sgwu_out_if.source            out_o
);

  // Configuration registers.
  logic [MU_W-1:0]  mu_p_q, mu_d_q;
  logic [PRM_W-1:0] sigma_p_q, alpha_p_q, sigma_d_q, beta_d_q, gain_p_q, gain_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_p_q    <= '0;
      sigma_p_q <= 16'd256;
      alpha_p_q <= 16'd256;
      mu_d_q    <= '0;
      sigma_d_q <= 16'd256;
      beta_d_q  <= 16'd256;
      gain_p_q  <= 16'd4096;
      gain_d_q  <= 16'd4096;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MU_P:    mu_p_q    <= cfg_data_i;
        REG_SIGMA_P: sigma_p_q <= cfg_data_i[PRM_W-1:0];
        REG_ALPHA_P: alpha_p_q <= cfg_data_i[PRM_W-1:0];
        REG_MU_D:    mu_d_q    <= cfg_data_i;
        REG_SIGMA_D: sigma_d_q <= cfg_data_i[PRM_W-1:0];
        REG_BETA_D:  beta_d_q  <= cfg_data_i[PRM_W-1:0];
        REG_GAIN_P:  gain_p_q  <= cfg_data_i[PRM_W-1:0];
        REG_GAIN_D:  gain_d_q  <= cfg_data_i[PRM_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits of the stages outside the divider and their load enables.
  logic v0_q, v1_q, v2_q, v3_q, v4_q, ve1_q, ve2_q, vm_q, vo_q;
  logic en0, en1, en2, en3, en4, ene1, ene2, enm, eno;
  logic div_in_ready, div_out_valid;

  assign eno  = !vo_q  || out_o.ready;
  assign enm  = !vm_q  || eno;
  assign ene2 = !ve2_q || enm;
  assign ene1 = !ve1_q || ene2;
  assign en4  = !v4_q  || div_in_ready;
  assign en3  = !v3_q  || en4;
  assign en2  = !v2_q  || en3;
  assign en1  = !v1_q  || en2;
  assign en0  = !v0_q  || en1;

  assign in_i.ready = en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      ve1_q <= 1'b0;
      ve2_q <= 1'b0;
      vm_q  <= 1'b0;
      vo_q  <= 1'b0;
    end else begin
      if (en0)  v0_q  <= in_i.valid;
      if (en1)  v1_q  <= v0_q;
      if (en2)  v2_q  <= v1_q;
      if (en3)  v3_q  <= v2_q;
      if (en4)  v4_q  <= v3_q;
      if (ene1) ve1_q <= div_out_valid;
      if (ene2) ve2_q <= ve1_q;
      if (enm)  vm_q  <= ve2_q;
      if (eno)  vo_q  <= vm_q;
    end
  end

  // Stage 0: pick the branch parameters and form d = mu - dt.
  tag_t             tag0_q;
  logic [34:0]      d0_q;
  logic [PRM_W-1:0] s0_q, k0_q, th0_q, g0_q;
  logic [32:0]      dt0;
  logic [MU_W-1:0]  mu0;
  logic [PRM_W-1:0] sig0;

  always_comb begin
    if (in_i.operation) begin
      dt0  = {1'b0, in_i.pre_spike_time} - {1'b0, in_i.post_spike_time};
      mu0  = mu_d_q;
      sig0 = sigma_d_q;
    end else begin
      dt0  = {1'b0, in_i.post_spike_time} - {1'b0, in_i.pre_spike_time};
      mu0  = mu_p_q;
      sig0 = sigma_p_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) begin
      tag0_q <= '{op: in_i.operation, idx: in_i.synapse_index, w: in_i.weight};
      d0_q   <= {{11{mu0[MU_W-1]}}, mu0} - {{2{dt0[32]}}, dt0};
      s0_q   <= (sig0 == '0) ? 16'd1 : sig0;
      k0_q   <= in_i.operation ? beta_d_q : alpha_p_q;
      th0_q  <= in_i.cooperativity;
      g0_q   <= in_i.operation ? gain_d_q : gain_p_q;
    end
  end

  // Stage 1: |d|, the far-outside-window test and the three narrow products.
  tag_t        tag1_q;
  logic        far1_q;
  logic [20:0] ad1_q;
  logic [31:0] ss1_q, m1_1_q;
  logic [22:0] xa1_q;
  logic [34:0] ad1;
  logic [31:0] xa1;

  assign ad1 = d0_q[34] ? (35'd0 - d0_q) : d0_q;
  assign xa1 = {16'b0, k0_q} * {16'b0, th0_q};

  always_ff @(posedge clk_i) begin
    if (en1) begin
      tag1_q <= tag0_q;
      far1_q <= ad1 >= {14'b0, s0_q, 5'b0};
      ad1_q  <= ad1[20:0];
      ss1_q  <= {16'b0, s0_q} * {16'b0, s0_q};
      m1_1_q <= {16'b0, tag0_q.w} * {16'b0, g0_q};
      xa1_q  <= (|xa1[31:23]) ? 23'h7FFFFF : xa1[22:0];
    end
  end

  // Stage 2: d squared and the scaled amplitude exponent.
  tag_t        tag2_q;
  logic        far2_q;
  logic [41:0] sq2_q;
  logic [31:0] ss2_q, m1_2_q;
  logic [23:0] ya2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      tag2_q <= tag1_q;
      far2_q <= far1_q;
      sq2_q  <= {21'b0, ad1_q} * {21'b0, ad1_q};
      ss2_q  <= ss1_q;
      m1_2_q <= m1_1_q;
      ya2_q  <= exp_scale(xa1_q);
    end
  end

  // Stage 3: amplitude; potentiation uses 2 - exp, depression exp itself.
  tag_t        tag3_q;
  logic        far3_q;
  logic [41:0] sq3_q;
  logic [31:0] ss3_q, m1_3_q;
  logic [17:0] amp3_q;
  logic [16:0] ea3;

  assign ea3 = exp_pow2(ya2_q);

  always_ff @(posedge clk_i) begin
    if (en3) begin
      tag3_q <= tag2_q;
      far3_q <= far2_q;
      sq3_q  <= sq2_q;
      ss3_q  <= ss2_q;
      m1_3_q <= m1_2_q;
      amp3_q <= tag2_q.op ? {1'b0, ea3} : (TWO_Q16 - {1'b0, ea3});
    end
  end

  // Stage 4: weight times gain times amplitude, ahead of the divider.
  div_side_t   side4_q;
  logic [41:0] sq4_q;
  logic [31:0] ss4_q;
  logic [49:0] p4;

  assign p4 = {18'b0, m1_3_q} * {32'b0, amp3_q};

  always_ff @(posedge clk_i) begin
    if (en4) begin
      side4_q <= '{tag: tag3_q, far: far3_q, p: p4[49:16]};
      sq4_q   <= sq3_q;
      ss4_q   <= ss3_q;
    end
  end

  // Window exponent x = d^2 * 2^15 / sigma^2.
  logic [QW-1:0] quo;
  div_side_t     side_div;

  sgwu_div u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (v4_q),
    .in_ready_o    (div_in_ready),
    .dividend_hi_i (sq4_q[41:10]),
    .dividend_lo_i ({sq4_q[9:0], 15'b0}),
    .divisor_i     (ss4_q),
    .side_i        (side4_q),
    .out_valid_o   (div_out_valid),
    .out_ready_i   (ene1),
    .quotient_o    (quo),
    .side_o        (side_div)
  );

  // Exp stage 1: saturate and scale the window exponent.
  div_side_t   side_e1_q;
  logic [23:0] yw_e1_q;
  logic [22:0] xw;

  assign xw = (|quo[QW-1:23]) ? 23'h7FFFFF : quo[22:0];

  always_ff @(posedge clk_i) begin
    if (ene1) begin
      side_e1_q <= side_div;
      yw_e1_q   <= exp_scale(xw);
    end
  end

  // Exp stage 2: window value, forced to zero far outside the window.
  div_side_t   side_e2_q;
  logic [16:0] g_e2_q;

  always_ff @(posedge clk_i) begin
    if (ene2) begin
      side_e2_q <= side_e1_q;
      g_e2_q    <= side_e1_q.far ? 17'd0 : exp_pow2(yw_e1_q);
    end
  end

  // Product stage: the Q.14 change of weight.
  tag_t        tag_m_q;
  logic [22:0] dl_m_q;
  logic [50:0] pg;

  assign pg = {17'b0, side_e2_q.p} * {34'b0, g_e2_q};

  always_ff @(posedge clk_i) begin
    if (enm) begin
      tag_m_q <= side_e2_q.tag;
      dl_m_q  <= pg[50:28];
    end
  end

  // Output register: apply the change with saturation.
  logic [IDX_W-1:0] idx_o_q;
  logic [WGT_W-1:0] nw_o_q;
  logic             clip_o_q;
  logic [23:0]      sum;
  logic [WGT_W-1:0] nw;
  logic             clip;

  always_comb begin
    sum = {8'b0, tag_m_q.w} + {1'b0, dl_m_q};
    if (!tag_m_q.op) begin
      clip = |sum[23:16];
      nw   = clip ? '1 : sum[15:0];
    end else begin
      clip = dl_m_q > {7'b0, tag_m_q.w};
      nw   = clip ? '0 : (tag_m_q.w - dl_m_q[15:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (eno) begin
      idx_o_q  <= tag_m_q.idx;
      nw_o_q   <= nw;
      clip_o_q <= clip;
    end
  end

  assign out_o.valid             = vo_q;
  assign out_o.synapse_index_out = idx_o_q;
  assign out_o.new_weight        = nw_o_q;
  assign out_o.clipped           = clip_o_q;

`ifndef SYNTH
  a_clip_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.clipped |-> (out_o.new_weight == '0 || out_o.new_weight == '1))
    else $error("clipped result is not at a rail");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> v0_q)
    else $error("accepted request did not enter the first stage");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v0_q |-> in_i.ready)
    else $error("first stage empty but request refused");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vm_q && vo_q && !out_o.ready |=> vm_q && vo_q)
    else $error("stalled stage dropped its item");
`endif

endmodule

>>> hdl/sgwu_div.sv
// ----------------------------------------------------------------------------
// sgwu_div: pipelined restoring divider for the window exponent
// One quotient bit per stage, side data travelling alongside.
// ----------------------------------------------------------------------------
module sgwu_div import sgwu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [REM_W-1:0] dividend_hi_i,
  input  logic [QW-1:0]    dividend_lo_i,
  input  logic [REM_W-1:0] divisor_i,
  input  div_side_t        side_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [QW-1:0]    quotient_o,
  output div_side_t        side_o
);

  logic [QW-1:0]    v_q;
  logic [QW-1:0]    en;
  logic [REM_W-1:0] rem_q [QW];
  logic [QW-1:0]    low_q [QW];
  logic [QW-1:0]    quo_q [QW];
  logic [REM_W-1:0] dvs_q [QW];
  div_side_t        side_q [QW];

  // A stage takes new data when it is empty or its successor moves on.
  always_comb begin
    en[QW-1] = !v_q[QW-1] || out_ready_i;
    for (int k = QW - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic             v_in;
    logic [REM_W-1:0] rem_in;
    logic [QW-1:0]    low_in;
    logic [QW-1:0]    quo_in;
    logic [REM_W-1:0] dvs_in;
    div_side_t        side_in;
    logic [REM_W:0]   trial;
    logic             ge;
    logic [REM_W:0]   diff;

    if (k == 0) begin : g_first
      assign v_in    = in_valid_i;
      assign rem_in  = dividend_hi_i;
      assign low_in  = dividend_lo_i;
      assign quo_in  = '0;
      assign dvs_in  = divisor_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign low_in  = low_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign dvs_in  = dvs_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign ge    = trial >= {1'b0, dvs_in};
    assign diff  = ge ? (trial - {1'b0, dvs_in}) : trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        rem_q[k]  <= diff[REM_W-1:0];
        low_q[k]  <= {low_in[QW-2:0], 1'b0};
        quo_q[k]  <= {quo_in[QW-2:0], ge};
        dvs_q[k]  <= dvs_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[QW-1];
  assign quotient_o  = quo_q[QW-1];
  assign side_o      = side_q[QW-1];

endmodule

>>> dv/tb_stdp_gaussian_weight_update.sv
// ----------------------------------------------------------------------------
// tb_stdp_gaussian_weight_update: self-checking bench for the STDP update
// Drives random and directed update requests with bursty flow and stalls on
// both sides, predicts each result in fixed point and checks it in order.
// ----------------------------------------------------------------------------
module tb_stdp_gaussian_weight_update;
  import sgwu_pkg::*;

  typedef struct packed {
    logic        op;
    logic [15:0] idx;
    logic [15:0] w;
    logic [15:0] theta;
    logic [31:0] pre;
    logic [31:0] post;
  } upd_req_t;

  typedef struct packed {
    logic [15:0] idx;
    logic [15:0] nw;
    logic        clip;
  } upd_res_t;

  // Each entry of the request list is either an update or a register write.
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    upd_req_t              req;
  } step_t;

  // Drain allowance for the register-write wait and the end-of-run wait.
  localparam int PIPE_LAT = 33;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  sgwu_in_if  req_ch ();
  sgwu_out_if res_ch ();

  stdp_gaussian_weight_update dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (req_ch.sink),
    .out_o     (res_ch.source)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the block's registers, indexed by register number.
  logic [23:0] shadow_reg [8];

  step_t    pending_steps[$];
  upd_res_t expected_weights[$];
  int       n_errors = 0;
  int       n_updates = 0;
  int       n_clipped = 0;
  bit       stim_done = 1'b0;
  bit       hold_off = 1'b0;

  // exp(-x) in Q.16 by table lookup with linear interpolation.
  function automatic logic [31:0] exp_neg(input logic [63:0] x);
    logic [63:0] y;
    logic [31:0] n;
    logic [31:0] fr;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] v;
    logic [31:0] tab [17];
    tab = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
            44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
    if (x > 64'h7FFFFF) x = 64'h7FFFFF;
    y = (x * 64'd94548) >> 16;
    n = 32'(y >> 16);
    if (n >= 32) return 32'd0;
    fr = 32'(y & 64'hFFFF);
    lo = tab[fr >> 12];
    hi = tab[(fr >> 12) + 1];
    v = lo - (((lo - hi) * (fr & 32'hFFF)) >> 12);
    return v >> n;
  endfunction

  // Gaussian timing window in Q.16 for a signed Q.8 time difference.
  function automatic logic [31:0] timing_window(input logic [23:0] mu,
                                                input logic [15:0] sigma,
                                                input longint dt);
    longint d;
    logic [63:0] ad;
    logic [63:0] s;
    d = longint'($signed(mu)) - dt;
    ad = (d < 0) ? 64'(-d) : 64'(d);
    s = (sigma == 16'd0) ? 64'd1 : 64'(sigma);
    if (ad >= 32 * s) return 32'd0;
    return exp_neg(((ad * ad) << 15) / (s * s));
  endfunction

  function automatic upd_res_t predict_weight(input upd_req_t r);
    upd_res_t   res;
    logic [63:0] amp;
    logic [63:0] g;
    logic [63:0] gain;
    logic [63:0] delta;
    logic [63:0] nw;
    longint      pre;
    longint      post;
    pre  = longint'(r.pre);
    post = longint'(r.post);
    res.clip = 1'b0;
    if (!r.op) begin
      amp  = 64'd131072 - exp_neg(64'(shadow_reg[REG_ALPHA_P][15:0]) * r.theta);
      g    = timing_window(shadow_reg[REG_MU_P], shadow_reg[REG_SIGMA_P][15:0],
                           post - pre);
      gain = shadow_reg[REG_GAIN_P][15:0];
    end else begin
      amp  = exp_neg(64'(shadow_reg[REG_BETA_D][15:0]) * r.theta);
      g    = timing_window(shadow_reg[REG_MU_D], shadow_reg[REG_SIGMA_D][15:0],
                           pre - post);
      gain = shadow_reg[REG_GAIN_D][15:0];
    end
    delta = ((((64'(r.w) * gain) * amp) >> 16) * g >> 16) >> 12;
    if (!r.op) begin
      nw = 64'(r.w) + delta;
      if (nw > 64'd65535) begin
        nw = 64'd65535;
        res.clip = 1'b1;
      end
    end else if (delta > 64'(r.w)) begin
      nw = 64'd0;
      res.clip = 1'b1;
    end else begin
      nw = 64'(r.w) - delta;
    end
    res.idx = r.idx;
    res.nw  = nw[15:0];
    return res;
  endfunction

  function automatic step_t make_update(input upd_req_t r);
    step_t s;
    s = '0;
    s.req = r;
    return s;
  endfunction

  function automatic step_t make_write(input logic [CFG_IDX_W-1:0] i,
                                       input logic [CFG_DATA_W-1:0] v);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.cfg_idx = i;
    s.cfg_data = v;
    return s;
  endfunction

  // Random request whose spike times sit near the window so that most
  // updates see a non-zero Gaussian; a share uses fully random times.
  function automatic upd_req_t rand_update();
    upd_req_t r;
    int       span;
    r.op    = $urandom_range(0, 1);
    r.idx   = $urandom;
    r.w     = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1) * 16'hFFFF)
                                          : 16'($urandom);
    r.theta = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
    r.pre   = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      r.post = $urandom;
    end else begin
      span   = $urandom_range(0, 3) == 0 ? 65536 : 4096;
      r.post = r.pre + 32'($urandom_range(0, 2 * span)) - 32'(span);
    end
    return r;
  endfunction

  // Stimulus list: directed corners under reset values, then several
  // register settings each followed by a random block.
  initial begin
    upd_req_t r;
    logic [23:0] extreme_set [8][4];
    for (int i = 0; i < 8; i++) shadow_reg[i] = '0;
    shadow_reg[REG_SIGMA_P] = 24'd256;
    shadow_reg[REG_ALPHA_P] = 24'd256;
    shadow_reg[REG_SIGMA_D] = 24'd256;
    shadow_reg[REG_BETA_D]  = 24'd256;
    shadow_reg[REG_GAIN_P]  = 24'd4096;
    shadow_reg[REG_GAIN_D]  = 24'd4096;

    // Directed part: field extremes, both operations, far window,
    // overflow and underflow.
    for (int k = 0; k < 20; k++) begin
      r.op    = k[0];
      r.idx   = (k < 4) ? 16'hFFFF : 16'(k);
      r.w     = (k < 6) ? 16'hFFFF : ((k < 8) ? 16'h0000 : 16'h4000);
      r.theta = (k % 3 == 0) ? 16'hFFFF : ((k % 3 == 1) ? 16'h0000 : 16'h0100);
      r.pre   = (k < 10) ? 32'h0 : 32'hFFFF_FFFF;
      r.post  = (k == 2 || k == 3) ? 32'hFFFF_FFFF : r.pre;
      if (k >= 12 && k < 16) r.post = r.pre + 32'd8192; // wraps round, so far outside 32 sigma
      pending_steps.push_back(make_update(r));
    end

    // Register settings: extremes and mid values; the zero sigma case and
    // widest gains are among them.
    extreme_set = '{
      '{24'h000000, 24'h7FFFFF, 24'h800000, 24'h000400},
      '{24'd0,      24'd1,      24'd65535,  24'd512},
      '{24'd0,      24'd65535,  24'd1,      24'd64},
      '{24'h000000, 24'h800000, 24'h7FFFFF, 24'hFFFC00},
      '{24'd0,      24'd65535,  24'd1,      24'd1024},
      '{24'd0,      24'd1,      24'd65535,  24'd32},
      '{24'd65535,  24'd0,      24'd4096,   24'd40000},
      '{24'd65535,  24'd4096,   24'd0,      24'd30000}
    };
    for (int phase = 0; phase < 7; phase++) begin
      pending_steps.push_back(make_write(3'd0, '0)); // popped again on the next line, so it leaves no entry
      pending_steps.pop_back();
      for (int i = 0; i < 8; i++) begin
        logic [23:0] v;
        v = (phase < 4) ? extreme_set[i][phase] : 24'($urandom);
        if (phase >= 4 && (i == REG_MU_P || i == REG_MU_D))
          v = 24'($signed($urandom_range(0, 8192)) - 4096);
        pending_steps.push_back(make_write(3'(i), v));
      end
      for (int k = 0; k < 200; k++) pending_steps.push_back(make_update(rand_update()));
    end
  end

  // Reset, then a fixed long receiver stall to fill the pipeline.
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b1;
    for (int c = 0; c < 150; c++) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Driver: bursts with random gaps. A register write waits until the
  // pipeline has drained and then for the drain_wait countdown to end.
  int     burst_left = 0;
  int     gap_left = 0;
  int     drain_wait = 0;
  step_t  cur;
  logic   req_taken = 1'b0;
  logic   cfg_we_d;

  // Request transfer seen at the rising edge, used by the driver on the
  // falling edge, when ready may already have moved on.
  always @(posedge clk_i) begin
    req_taken <= req_ch.valid && req_ch.ready;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      cfg_we_d = 1'b0;
      if (!(req_ch.valid && !req_taken)) begin
        if (pending_steps.size() == 0) begin
          req_ch.valid <= 1'b0;
          stim_done = 1'b1;
        end else if (pending_steps[0].is_cfg) begin
          req_ch.valid <= 1'b0;
          if (expected_weights.size() != 0 || req_ch.valid) begin
            drain_wait = PIPE_LAT + 4;
          end else if (drain_wait > 0) begin
            drain_wait--;
          end else begin
            cur = pending_steps.pop_front();
            cfg_we_d    = 1'b1;
            cfg_idx_i  <= cur.cfg_idx;
            cfg_data_i <= cur.cfg_data;
            shadow_reg[cur.cfg_idx] = cur.cfg_data;
          end
        end else if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else begin
          cur = pending_steps.pop_front();
          req_ch.valid           <= 1'b1;
          req_ch.operation       <= cur.req.op;
          req_ch.synapse_index   <= cur.req.idx;
          req_ch.weight          <= cur.req.w;
          req_ch.cooperativity   <= cur.req.theta;
          req_ch.pre_spike_time  <= cur.req.pre;
          req_ch.post_spike_time <= cur.req.post;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      cfg_we_i <= cfg_we_d;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.operation = 1'b0;
    req_ch.synapse_index = '0;
    req_ch.weight = '0;
    req_ch.cooperativity = '0;
    req_ch.pre_spike_time = '0;
    req_ch.post_spike_time = '0;
    res_ch.ready = 1'b0;
  end

  // Receiver stall pattern: long ready runs alternating with short stalls,
  // overridden by the hold-off window.
  int stall_phase = 0;
  always @(negedge clk_i) begin
    stall_phase <= (stall_phase + 1) % 64;
    res_ch.ready <= rst_ni && !hold_off &&
                    ((stall_phase < 32) || ($urandom_range(0, 2) != 0));
  end

  // Monitor: predict on every accepted request, check every accepted result.
  always @(posedge clk_i) begin
    upd_res_t exp_res;
    if (rst_ni && req_ch.valid && req_ch.ready) begin
      expected_weights.push_back(predict_weight({req_ch.operation,
        req_ch.synapse_index, req_ch.weight, req_ch.cooperativity,
        req_ch.pre_spike_time, req_ch.post_spike_time}));
    end
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      n_updates++;
      if (res_ch.clipped) n_clipped++;
      if (expected_weights.size() == 0) begin
        $error("unexpected result: index %0d", res_ch.synapse_index_out);
        n_errors++;
      end else begin
        exp_res = expected_weights.pop_front();
        if (res_ch.synapse_index_out !== exp_res.idx) begin
          $error("synapse_index_out expected %0d got %0d", exp_res.idx,
                 res_ch.synapse_index_out);
          n_errors++;
        end
        if (res_ch.new_weight !== exp_res.nw) begin
          $error("new_weight expected %0d got %0d", exp_res.nw, res_ch.new_weight);
          n_errors++;
        end
        if (res_ch.clipped !== exp_res.clip) begin
          $error("clipped expected %0d got %0d", exp_res.clip, res_ch.clipped);
          n_errors++;
        end
      end
    end
  end

  // End of run: all stimulus sent and every expected result back.
  initial begin
    wait (stim_done && expected_weights.size() == 0);
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    if (expected_weights.size() != 0) n_errors++;
    $display("Checked %0d weight updates (%0d saturated) over 8 register settings.",
             n_updates, n_clipped);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
